/* sv/c2d3_pkg.sv */
// Shared types, widths and register codes for the 3x3 streaming correlator.
package c2d3_pkg;

	localparam int PIX_W          = 8;
	localparam int COEF_W         = 8;
	localparam int KSIZE          = 3;
	localparam int KROW_W         = KSIZE * COEF_W;
	localparam int SIZE_W         = 11;
	localparam int POS_W          = 10;
	localparam int SUM_W          = 20;
	localparam int PROD_W         = PIX_W + COEF_W + 1;
	localparam int PART_W         = 18;
	localparam int CFG_IDX_W      = 3;
	localparam int SIZE_RESET     = 1024;
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KTOP   = 3'd0,
		REG_KMID   = 3'd1,
		REG_KBOT   = 3'd2,
		REG_WIDTH  = 3'd3,
		REG_HEIGHT = 3'd4
	} cfg_reg_t;

	// One window column, oldest row on top
	typedef struct packed {
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] bot;
	} pix_col_t;

	// Kernel coefficients for one window column
	typedef struct packed {
		logic signed [COEF_W-1:0] top;
		logic signed [COEF_W-1:0] mid;
		logic signed [COEF_W-1:0] bot;
	} coef_col_t;

	// Per-cycle controls for the cell chain
	typedef struct packed {
		logic shift;
		logic calc;
	} cell_ctl_t;

endpackage

/* sv/c2d3_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module c2d3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read; data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* sv/c2d3_cell.sv */
// Window cell: holds one window column and forms its weighted column sum.
module c2d3_cell (
	input  logic                               clk,
	input  logic                               arst_n,
	input  c2d3_pkg::cell_ctl_t                ctl,
	input  c2d3_pkg::pix_col_t                 col_in,
	input  c2d3_pkg::coef_col_t                coef,
	output c2d3_pkg::pix_col_t                 col_out,
	output logic signed [c2d3_pkg::PART_W-1:0] partial_s3
);

	c2d3_pkg::pix_col_t                       col_q;
	logic signed [c2d3_pkg::PROD_W-1:0]       p_top;
	logic signed [c2d3_pkg::PROD_W-1:0]       p_mid;
	logic signed [c2d3_pkg::PROD_W-1:0]       p_bot;

	// Take the neighbour's column when the window advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (ctl.shift) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;

	// Three pixel by coefficient products; pixels are unsigned
	always_comb begin
		p_top = $signed({1'b0, col_q.top}) * $signed(coef.top);
		p_mid = $signed({1'b0, col_q.mid}) * $signed(coef.mid);
		p_bot = $signed({1'b0, col_q.bot}) * $signed(coef.bot);
	end

	// Register the column sum for the final adder
	always_ff @(posedge clk) begin
		if (ctl.calc) begin
			partial_s3 <= c2d3_pkg::PART_W'(p_top) + c2d3_pkg::PART_W'(p_mid)
				+ c2d3_pkg::PART_W'(p_bot);
		end
	end

endmodule

/* sv/conv2d_3x3_valid.sv */
// Top level: streaming 3x3 correlation with line stores and a chain of window cells.
// Throughput: one pixel per cycle while pixel_stall is low, bounded by one read and
// one write per line store. Each result passes stages 1 to 3 and the result register.
// A stalled result port backs up the four-stage pipeline; pixel_stall rises when full.
// Reset clears pipeline valids, counters, window, kernel (zero) and sizes (1024).
// Line stores are not cleared; their entries are written before they are read.
module conv2d_3x3_valid #(
	parameter int MAX_WIDTH  = c2d3_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = c2d3_pkg::MAX_HEIGHT_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 pixel_valid,
	output logic                                 pixel_stall,
	input  logic [c2d3_pkg::PIX_W-1:0]           pixel,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic signed [c2d3_pkg::SUM_W-1:0]    filtered_value,
	output logic [c2d3_pkg::POS_W-1:0]           centre_row,
	output logic [c2d3_pkg::POS_W-1:0]           centre_column,
	output logic                                 frame_done,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [c2d3_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [c2d3_pkg::KROW_W-1:0]          cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	// Configuration registers
	logic [c2d3_pkg::KROW_W-1:0] ktop_q;
	logic [c2d3_pkg::KROW_W-1:0] kmid_q;
	logic [c2d3_pkg::KROW_W-1:0] kbot_q;
	logic [c2d3_pkg::SIZE_W-1:0] image_width_q;
	logic [c2d3_pkg::SIZE_W-1:0] image_height_q;

	// Position counters and effective sizes
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] wlast;
	logic [RW-1:0] hlast;
	logic [CW-1:0] col_e;
	logic [RW-1:0] row_e;

	// Pipeline control
	logic accept;
	logic rdy_out, free_s3, free_s2, free_s1;
	logic mv_s1, adv_s2, adv_s3;

	logic                          v_s1, res_s1, last_s1;
	logic [c2d3_pkg::PIX_W-1:0]    px_s1;
	logic [CW-1:0]                 col_s1;
	logic [c2d3_pkg::POS_W-1:0]    crow_s1, ccol_s1;

	logic                          v_s2, last_s2;
	logic [c2d3_pkg::POS_W-1:0]    crow_s2, ccol_s2;

	logic                          v_s3, last_s3;
	logic [c2d3_pkg::POS_W-1:0]    crow_s3, ccol_s3;

	logic                          result_valid_q;

	// Line store read data
	logic [c2d3_pkg::PIX_W-1:0] up2, up1;

	// Cell chain
	c2d3_pkg::cell_ctl_t                cell_ctl;
	c2d3_pkg::pix_col_t                 new_col;
	c2d3_pkg::pix_col_t                 col_chain [c2d3_pkg::KSIZE];
	logic signed [c2d3_pkg::PART_W-1:0] part_s3 [c2d3_pkg::KSIZE];

	assign cfg_ready = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ktop_q         <= '0;
			kmid_q         <= '0;
			kbot_q         <= '0;
			image_width_q  <= c2d3_pkg::SIZE_W'(c2d3_pkg::SIZE_RESET);
			image_height_q <= c2d3_pkg::SIZE_W'(c2d3_pkg::SIZE_RESET);
		end else if (cfg_valid && cfg_ready) begin
			case (c2d3_pkg::cfg_reg_t'(cfg_index))
				c2d3_pkg::REG_KTOP: begin
					ktop_q <= cfg_data;
				end
				c2d3_pkg::REG_KMID: begin
					kmid_q <= cfg_data;
				end
				c2d3_pkg::REG_KBOT: begin
					kbot_q <= cfg_data;
				end
				c2d3_pkg::REG_WIDTH: begin
					image_width_q <= cfg_data[c2d3_pkg::SIZE_W-1:0];
				end
				c2d3_pkg::REG_HEIGHT: begin
					image_height_q <= cfg_data[c2d3_pkg::SIZE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Clamp the frame size and derive the last column and row
	always_comb begin
		if (image_width_q < c2d3_pkg::SIZE_W'(3)) begin
			wlast = CW'(2);
		end else if (32'(image_width_q) > MAX_WIDTH) begin
			wlast = CW'(MAX_WIDTH - 1);
		end else begin
			wlast = CW'(image_width_q - 1'b1);
		end
		if (image_height_q < c2d3_pkg::SIZE_W'(3)) begin
			hlast = RW'(2);
		end else if (32'(image_height_q) > MAX_HEIGHT) begin
			hlast = RW'(MAX_HEIGHT - 1);
		end else begin
			hlast = RW'(image_height_q - 1'b1);
		end
		col_e = (col_q >= wlast) ? wlast : col_q;
		row_e = (row_q >= hlast) ? hlast : row_q;
	end

	// Ready chain from the result register back to the pixel port
	always_comb begin
		rdy_out     = !result_valid_q || !result_stall;
		adv_s3      = v_s3 && rdy_out;
		free_s3     = !v_s3 || rdy_out;
		adv_s2      = v_s2 && free_s3;
		free_s2     = !v_s2 || free_s3;
		mv_s1       = v_s1 && free_s2;
		free_s1     = !v_s1 || free_s2;
		pixel_stall = !free_s1;
		accept      = pixel_valid && free_s1;
	end

	// Advance the raster position on each pixel transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_e >= wlast) begin
				col_q <= '0;
				row_q <= (row_e >= hlast) ? '0 : row_e + 1'b1;
			end else begin
				col_q <= col_e + 1'b1;
				row_q <= row_e;
			end
		end
	end

	// Stage 1: line store read in flight, pixel and position held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (free_s1) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= pixel;
			col_s1  <= col_e;
			res_s1  <= (32'(row_e) >= 2) && (32'(col_e) >= 2);
			last_s1 <= (row_e == hlast) && (col_e == wlast);
			crow_s1 <= c2d3_pkg::POS_W'(32'(row_e) - 1);
			ccol_s1 <= c2d3_pkg::POS_W'(32'(col_e) - 1);
		end
	end

	// Line stores: read at transfer, rotate rows when stage 1 moves on
	c2d3_ram #(
		.WIDTH(c2d3_pkg::PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_older (
		.clk   (clk),
		.we    (mv_s1),
		.waddr (col_s1),
		.wdata (up1),
		.re    (accept),
		.raddr (col_e),
		.rdata (up2)
	);

	c2d3_ram #(
		.WIDTH(c2d3_pkg::PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_newer (
		.clk   (clk),
		.we    (mv_s1),
		.waddr (col_s1),
		.wdata (px_s1),
		.re    (accept),
		.raddr (col_e),
		.rdata (up1)
	);

	// Stage 2: window shifted; only interior positions carry on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (free_s2) begin
			v_s2 <= mv_s1 && res_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (mv_s1) begin
			crow_s2 <= crow_s1;
			ccol_s2 <= ccol_s1;
			last_s2 <= last_s1;
		end
	end

	// Stage 3: column sums registered in the cells
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (free_s3) begin
			v_s3 <= adv_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			crow_s3 <= crow_s2;
			ccol_s3 <= ccol_s2;
			last_s3 <= last_s2;
		end
	end

	// Cell chain: the newest column enters at the right-hand cell
	always_comb begin
		cell_ctl.shift = mv_s1;
		cell_ctl.calc  = adv_s2;
		new_col.top    = up2;
		new_col.mid    = up1;
		new_col.bot    = px_s1;
	end

	for (genvar j = 0; j < c2d3_pkg::KSIZE; j++) begin : g_cell
		c2d3_pkg::pix_col_t  cin;
		c2d3_pkg::coef_col_t cf;

		if (j == c2d3_pkg::KSIZE - 1) begin : g_last
			assign cin = new_col;
		end else begin : g_mid
			assign cin = col_chain[j+1];
		end

		assign cf.top = ktop_q[j*c2d3_pkg::COEF_W +: c2d3_pkg::COEF_W];
		assign cf.mid = kmid_q[j*c2d3_pkg::COEF_W +: c2d3_pkg::COEF_W];
		assign cf.bot = kbot_q[j*c2d3_pkg::COEF_W +: c2d3_pkg::COEF_W];

		c2d3_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (cell_ctl),
			.col_in     (cin),
			.coef       (cf),
			.col_out    (col_chain[j]),
			.partial_s3 (part_s3[j])
		);
	end

	// Result register: add the column sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (rdy_out) begin
			result_valid_q <= adv_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			filtered_value <= c2d3_pkg::SUM_W'(part_s3[0]) + c2d3_pkg::SUM_W'(part_s3[1])
				+ c2d3_pkg::SUM_W'(part_s3[2]);
			centre_row     <= crow_s3;
			centre_column  <= ccol_s3;
			frame_done     <= last_s3;
		end
	end

	assign result_valid = result_valid_q;

	// A transfer always lands in stage 1
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v_s1)
		else $error("pixel transfer did not reach stage 1");

	// Back-pressure only when every stage holds an item
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall |-> (v_s1 && v_s2 && v_s3 && result_valid_q))
		else $error("pixel port stalled with a free stage");

	// A new result comes only from stage 3
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(v_s3))
		else $error("result appeared without a stage 3 item");

endmodule
